FILE: design/set_of_bounded_stacks_top_defines.svh
// assertion macros for the bounded stack set
// used by set_of_bounded_stacks_top only, no other dependencies
`ifndef SET_OF_BOUNDED_STACKS_TOP_DEFINES_SVH
`define SET_OF_BOUNDED_STACKS_TOP_DEFINES_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define SOBS_CHECK_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sobs check failed");

// antecedent implies consequent in the next cycle
`define SOBS_CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sobs check failed");

`else

`define SOBS_CHECK_NOW(lbl, clk, rst_n, ante, cons)
`define SOBS_CHECK_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/sobs_pkg.sv
// shared types, sizes and codes for the bounded stack set
// no dependencies
package sobs_pkg;

    localparam int MAX_STACKS  = 16;
    localparam int STACK_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;

    localparam int IDX_W   = 4;   // stack_index field
    localparam int TOTAL_W = 5;   // stack_total field
    localparam int CAP_W   = 5;   // stack_capacity register
    localparam int RD_W    = 32;  // read_value field
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 3;

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ADDR_W = ((MAX_STACKS * STACK_DEPTH) > 1) ?
                            $clog2(MAX_STACKS * STACK_DEPTH) : 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 40;  // value, stack_index, zero pad
    localparam int M_TDATA_W = 40;  // read_value, stack_total, zero pad

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH    = 3'd0,
        F_POP     = 3'd1,
        F_PUSH_AT = 3'd2,
        F_POP_AT  = 3'd3,
        F_PEEK    = 3'd4,
        F_PEEK_AT = 3'd5,
        F_CLEAR   = 3'd6,
        F_NOP     = 3'd7
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NO_STACK = 3'd2,
        ST_FULL     = 3'd3,
        ST_NO_ROOM  = 3'd4
    } t_status;

    typedef enum logic {
        S_EXEC = 1'b0,
        S_DONE = 1'b1
    } t_back_state;

    // classified item as it travels from front to back
    typedef struct packed {
        t_func                 func;
        logic                  at_form;   // acts on stack_index
        logic                  removes;   // pop or pop_at
        logic [DATA_WIDTH-1:0] value;
        logic [IDX_W-1:0]      idx;
    } t_op;

    // back side status seen by the top level
    typedef struct packed {
        logic               take;
        logic [TOTAL_W-1:0] total;
    } t_back_stat;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] stack,
                                                   input logic [PTR_W-1:0] ptr);
        logic [ADDR_W+IDX_W-1:0] base;
        base = (ADDR_W+IDX_W)'(stack) * (ADDR_W+IDX_W)'(STACK_DEPTH);
        return ADDR_W'(base + (ADDR_W+IDX_W)'(ptr));
    endfunction

endpackage

FILE: design/sobs_front.sv
// front end: unpacks the input stream and classifies each item
// depends on sobs_pkg
module sobs_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: value[31:0], stack_index[35:32], zero pad
    input  logic [sobs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: func[2:0]
    input  logic [sobs_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                              o_push,
    output sobs_pkg::t_op                     o_op,
    input  logic                              i_full
);
    import sobs_pkg::*;

    t_func func;
    logic  r_seen;   // has left reset; holds ready low for the reset cycle

    assign func = t_func'(s_axis_tuser);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

    assign s_axis_tready = r_seen && !i_full;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        o_op         = '0;
        o_op.func    = func;
        o_op.value   = DATA_WIDTH'(s_axis_tdata[RD_W-1:0]);
        o_op.idx     = s_axis_tdata[RD_W +: IDX_W];
        case (func)
            F_PUSH_AT, F_PEEK_AT: begin
                o_op.at_form = 1'b1;
            end
            F_POP_AT: begin
                o_op.at_form = 1'b1;
                o_op.removes = 1'b1;
            end
            F_POP: begin
                o_op.removes = 1'b1;
            end
            default: begin
                o_op.at_form = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/sobs_queue.sv
// short item queue between front and back
// depends on sobs_pkg
module sobs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sobs_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sobs_pkg::t_op o_op
);
    import sobs_pkg::*;

    t_op               r_item [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_item[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_item[r_wr_ptr] <= i_op;
        end
    end

endmodule

FILE: design/sobs_back.sv
// back end: stack bookkeeping, word memory and result register
// depends on sobs_pkg
module sobs_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sobs_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic                           i_valid,
    input  sobs_pkg::t_op                  i_op,
    output logic                           o_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: read_value[31:0], stack_total[36:32], zero pad
    output logic [sobs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [sobs_pkg::STAT_W-1:0]    m_axis_tuser,
    output sobs_pkg::t_back_stat           o_stat
);
    import sobs_pkg::*;

    t_back_state r_state, n_state;

    logic [CAP_W-1:0]      r_cap;
    logic [FILL_W-1:0]     r_fill [MAX_STACKS];
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic [DATA_WIDTH-1:0] r_mem [MAX_STACKS * STACK_DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_q;
    logic                  r_use_read;
    t_status               r_status, n_status;

    logic                  r_out_valid;
    logic [RD_W-1:0]       r_out_rd;
    logic [TOTAL_W-1:0]    r_out_total;
    t_status               r_out_status;

    logic                  take, load;
    logic [FILL_W-1:0]     eff_cap;
    logic [TOTAL_W-1:0]    total_m1;
    logic [IDX_W-1:0]      top, tgt;
    logic [FILL_W-1:0]     tgt_fill, fill_m1;
    logic                  tgt_full, exists;

    logic                  wr_en, rd_en, fill_we, clear_all;
    logic [IDX_W-1:0]      acc_stack, fill_sel;
    logic [PTR_W-1:0]      acc_ptr;
    logic [FILL_W-1:0]     fill_val;
    logic [ADDR_W-1:0]     acc_addr;

    // capacity zero acts as one, above the depth acts as the depth
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = FILL_W'(1);
        end else if (int'(r_cap) > STACK_DEPTH) begin
            eff_cap = FILL_W'(STACK_DEPTH);
        end else begin
            eff_cap = FILL_W'(r_cap);
        end
    end

    assign total_m1 = r_total - TOTAL_W'(1);
    assign top      = total_m1[IDX_W-1:0];
    assign tgt      = i_op.at_form ? i_op.idx : top;
    assign tgt_fill = r_fill[tgt];
    assign fill_m1  = tgt_fill - FILL_W'(1);
    assign tgt_full = (tgt_fill >= eff_cap);
    assign exists   = (TOTAL_W'(i_op.idx) < r_total);
    assign acc_addr = mem_addr(acc_stack, acc_ptr);

    // operation decode against the current stack state
    always_comb begin
        n_status  = ST_OK;
        n_total   = r_total;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        fill_we   = 1'b0;
        clear_all = 1'b0;
        acc_stack = tgt;
        acc_ptr   = tgt_fill[PTR_W-1:0];
        fill_sel  = tgt;
        fill_val  = tgt_fill + FILL_W'(1);
        case (i_op.func)
            F_PUSH: begin
                if (r_total == '0) begin
                    wr_en     = 1'b1;
                    fill_we   = 1'b1;
                    acc_stack = '0;
                    acc_ptr   = '0;
                    fill_sel  = '0;
                    fill_val  = FILL_W'(1);
                    n_total   = TOTAL_W'(1);
                end else if (tgt_full) begin
                    if (int'(r_total) >= MAX_STACKS) begin
                        n_status = ST_NO_ROOM;
                    end else begin
                        // open the next stack
                        wr_en     = 1'b1;
                        fill_we   = 1'b1;
                        acc_stack = r_total[IDX_W-1:0];
                        acc_ptr   = '0;
                        fill_sel  = r_total[IDX_W-1:0];
                        fill_val  = FILL_W'(1);
                        n_total   = r_total + TOTAL_W'(1);
                    end
                end else begin
                    wr_en   = 1'b1;
                    fill_we = 1'b1;
                end
            end
            F_POP, F_PEEK: begin
                if (r_total == '0 || tgt_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    acc_ptr = fill_m1[PTR_W-1:0];
                    if (i_op.removes) begin
                        fill_we  = 1'b1;
                        fill_val = fill_m1;
                        // emptied top stack is dropped
                        if (fill_m1 == '0) begin
                            n_total = total_m1;
                        end
                    end
                end
            end
            F_PUSH_AT: begin
                if (!exists) begin
                    n_status = ST_NO_STACK;
                end else if (tgt_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    fill_we = 1'b1;
                end
            end
            F_POP_AT, F_PEEK_AT: begin
                if (!exists) begin
                    n_status = ST_NO_STACK;
                end else if (tgt_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    acc_ptr = fill_m1[PTR_W-1:0];
                    if (i_op.removes) begin
                        fill_we  = 1'b1;
                        fill_val = fill_m1;
                    end
                end
            end
            F_CLEAR: begin
                clear_all = 1'b1;
                n_total   = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_EXEC: begin
                if (take) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_EXEC;
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        take = 1'b0;
        load = 1'b0;
        case (r_state)
            S_EXEC: begin
                take = i_valid && (!r_out_valid || m_axis_tready);
            end
            S_DONE: begin
                load = 1'b1;
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EXEC;
            r_cap       <= CAP_RESET;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < MAX_STACKS; s++) begin
                r_fill[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (take) begin
                r_total <= n_total;
                if (clear_all) begin
                    for (int s = 0; s < MAX_STACKS; s++) begin
                        r_fill[s] <= '0;
                    end
                end else if (fill_we) begin
                    r_fill[fill_sel] <= fill_val;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word memory, registered read
    always_ff @(posedge i_clk) begin
        if (take && wr_en) begin
            r_mem[acc_addr] <= i_op.value;
        end
        if (take && rd_en) begin
            r_mem_q <= r_mem[acc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_use_read <= rd_en;
            r_status   <= n_status;
        end
        if (load) begin
            r_out_rd     <= r_use_read ? RD_W'(r_mem_q) : '0;
            r_out_status <= r_status;
            r_out_total  <= r_total;
        end
    end

    assign o_pop         = take;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_total, r_out_rd});
    assign m_axis_tuser  = r_out_status;
    assign o_stat.take   = take;
    assign o_stat.total  = r_total;

endmodule

FILE: design/set_of_bounded_stacks_top.sv
// Set of bounded stacks with push, pop, indexed access, peek and clear.
// Input channel s_axis: one operation per item, func in tuser, value and
// stack_index in tdata. Output channel m_axis: one result per item,
// read_value and stack_total in tdata, status in tuser.
// Configuration: i_cfg_we writes i_cfg_wdata into the stack capacity.
// Write it only while no item is in flight.
// A result becomes valid once its item has passed the queue, the back end's
// S_EXEC and S_DONE states and the result register. The back end takes no
// new item while in S_DONE: it decodes and updates the stack counters in
// S_EXEC and loads the registered memory read into the result in S_DONE.
// A two-entry queue sits between the front end and the back end, and the
// result register lets the next item start in the cycle its predecessor's
// result is taken. When m_axis_tready stays low the result holds, the back
// end stops, the queue fills and s_axis_tready falls.
// Reset (synchronous, active low) empties all stacks, sets the capacity to
// 16 and drops any queued item or pending result; the word memory is not
// cleared and needs no clearing pass.
// depends on sobs_pkg, sobs_front, sobs_queue, sobs_back
module set_of_bounded_stacks_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sobs_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: value[31:0], stack_index[35:32], zero pad
    input  logic [sobs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: func[2:0]
    input  logic [sobs_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: read_value[31:0], stack_total[36:32], zero pad
    output logic [sobs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [sobs_pkg::STAT_W-1:0]    m_axis_tuser
);
    import sobs_pkg::*;

`include "set_of_bounded_stacks_top_defines.svh"

    logic       q_push, q_full, q_valid, q_pop;
    t_op        front_op, back_op;
    t_back_stat back_stat;

    sobs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (q_push),
        .o_op          (front_op),
        .i_full        (q_full)
    );

    sobs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (back_op)
    );

    sobs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (q_valid),
        .i_op          (back_op),
        .o_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_stat        (back_stat)
    );

    `SOBS_CHECK_NOW(a_total_bound, i_clk, i_rst_n, 1'b1,
        int'(back_stat.total) <= MAX_STACKS)
    `SOBS_CHECK_NOW(a_take_needs_slot, i_clk, i_rst_n, back_stat.take,
        q_valid && (!m_axis_tvalid || m_axis_tready))
    `SOBS_CHECK_NOW(a_no_room_means_all_used, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser == ST_NO_ROOM),
        int'(back_stat.total) == MAX_STACKS)
    `SOBS_CHECK_NEXT(a_take_gives_result, i_clk, i_rst_n, back_stat.take,
        !back_stat.take ##1 m_axis_tvalid)

endmodule
